### design/pfcs_pkg.sv
// Package for the parallel flash command sequencer.
// Holds opcodes, phases, bus constants and the job/result types; no dependencies.

package pfcs_pkg;

    // Number of memory address lines; bus addresses are reduced to this width
    localparam int ADDR_WIDTH = 16;
    localparam logic [15:0] BUS_ADDR_MASK =
        (ADDR_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << ADDR_WIDTH) - 32'd1);

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Longest bus cycle list caused by one request
    localparam int MAX_RESULTS = 7;
    localparam int STEP_W      = $clog2(MAX_RESULTS);

    // JEDEC unlock and command bytes
    localparam logic [15:0] UNLOCK_ADDR1     = 16'h5555;
    localparam logic [15:0] UNLOCK_ADDR2     = 16'h2AAA;
    localparam logic [7:0]  UNLOCK_DATA1     = 8'hAA;
    localparam logic [7:0]  UNLOCK_DATA2     = 8'h55;
    localparam logic [7:0]  CMD_PROGRAM      = 8'hA0;
    localparam logic [7:0]  CMD_ERASE_SETUP  = 8'h80;
    localparam logic [7:0]  CMD_CHIP_ERASE   = 8'h10;
    localparam logic [7:0]  CMD_SECTOR_ERASE = 8'h30;
    localparam logic [7:0]  CMD_ID_ENTRY     = 8'h90;
    localparam logic [7:0]  CMD_ID_EXIT      = 8'hF0;
    localparam logic [7:0]  CMD_UNPROTECT    = 8'h20;
    localparam logic [7:0]  ERASED_BYTE      = 8'hFF;
    localparam logic [15:0] ID_FAMILY_ADDR   = 16'h0000;
    localparam logic [15:0] ID_DEVICE_ADDR   = 16'h0001;

    typedef enum logic [2:0] {
        OP_READ         = 3'd0,
        OP_WRITE        = 3'd1,
        OP_PROGRAM      = 3'd2,
        OP_SECTOR_ERASE = 3'd3,
        OP_CHIP_ERASE   = 3'd4,
        OP_READ_ID      = 3'd5,
        OP_UNPROTECT    = 3'd6,
        OP_BUS_RESP     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_READ    = 3'd1,
        PH_POLL    = 3'd2,
        PH_ID_HIGH = 3'd3,
        PH_ID_LOW  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    // Bus cycle list the back end plays out for one job
    typedef enum logic [3:0] {
        SEQ_READ         = 4'd0,
        SEQ_WRITE        = 4'd1,
        SEQ_DONE         = 4'd2,
        SEQ_REJECT       = 4'd3,
        SEQ_PROGRAM      = 4'd4,
        SEQ_SECTOR_ERASE = 4'd5,
        SEQ_CHIP_ERASE   = 4'd6,
        SEQ_UNPROTECT    = 4'd7,
        SEQ_READ_ID      = 4'd8,
        SEQ_ID_DONE      = 4'd9
    } seq_t;

    typedef struct packed {
        seq_t        seq;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] host_data;
    } job_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic [15:0] host_data;
        logic        done_res;
        logic        last;
    } res_t;

    // Reduce an address to the memory's address lines
    function automatic logic [15:0] bus_addr(logic [15:0] a);
        return a & BUS_ADDR_MASK;
    endfunction

endpackage

### design/pfcs_req_if.sv
// Request channel of the parallel flash command sequencer.
// Valid/ready handshake with the host request payload; no dependencies.

interface pfcs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  sector;
    logic [7:0]  read_data;

    modport source (output valid, output operation, output address, output data,
                    output sector, output read_data, input ready);
    modport sink   (input valid, input operation, input address, input data,
                    input sector, input read_data, output ready);
endinterface

### design/pfcs_res_if.sv
// Result channel of the parallel flash command sequencer.
// Valid/ready handshake carrying one bus cycle per transfer; no dependencies.

interface pfcs_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cycle_kind;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic [15:0] host_data;
    logic        done_res;
    logic        last;

    modport source (output valid, output cycle_kind, output bus_address, output bus_data,
                    output host_data, output done_res, output last, input ready);
    modport sink   (input valid, input cycle_kind, input bus_address, input bus_data,
                    input host_data, input done_res, input last, output ready);
endinterface

### design/pfcs_front.sv
// Front end: accepts requests, tracks the operation phase and turns each request into a job.
// Depends on pfcs_pkg and pfcs_req_if.

module pfcs_front (
    input  logic            clk,
    input  logic            rst_n,
    pfcs_req_if.sink        req,
    output logic            job_valid,
    input  logic            job_ready,
    output pfcs_pkg::job_t  job
);
    import pfcs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] poll_addr_reg, poll_addr_next;
    logic [7:0]  expected_reg, expected_next;
    logic [7:0]  id_high_reg, id_high_next;

    op_t         op;
    logic        accept;
    logic        rd_match;
    logic [15:0] sector_addr;

    assign op          = op_t'(req.operation);
    assign req.ready   = job_ready;
    assign accept      = req.valid && job_ready;
    assign rd_match    = (req.read_data == expected_reg);
    assign sector_addr = bus_addr({req.sector, 8'h00});

    // Phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (op == OP_BUS_RESP)
            begin
                unique case (phase_reg)
                    PH_READ:    phase_next = PH_IDLE;
                    PH_POLL:    phase_next = rd_match ? PH_IDLE : PH_POLL;
                    PH_ID_HIGH: phase_next = PH_ID_LOW;
                    PH_ID_LOW:  phase_next = PH_IDLE;
                    default:    phase_next = phase_reg;
                endcase
            end
            else if (phase_reg == PH_IDLE)
            begin
                unique case (op) inside
                    OP_READ:                                      phase_next = PH_READ;
                    OP_PROGRAM, OP_SECTOR_ERASE, OP_CHIP_ERASE:   phase_next = PH_POLL;
                    OP_READ_ID:                                   phase_next = PH_ID_HIGH;
                    default:                                      phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Job decode and poll/id bookkeeping
    always_comb
    begin
        job_valid      = 1'b0;
        job.seq        = SEQ_REJECT;
        job.addr       = '0;
        job.data       = '0;
        job.host_data  = '0;
        poll_addr_next = poll_addr_reg;
        expected_next  = expected_reg;
        id_high_next   = id_high_reg;
        if (accept)
        begin
            job_valid = 1'b1;
            if (op == OP_BUS_RESP)
            begin
                unique case (phase_reg)
                    PH_READ:
                    begin
                        job.seq       = SEQ_DONE;
                        job.host_data = {8'h00, req.read_data};
                    end
                    PH_POLL:
                    begin
                        if (rd_match)
                        begin
                            job.seq       = SEQ_DONE;
                            job.host_data = {8'h00, req.read_data};
                        end
                        else
                        begin
                            job.seq  = SEQ_READ;
                            job.addr = poll_addr_reg;
                        end
                    end
                    PH_ID_HIGH:
                    begin
                        id_high_next = req.read_data;
                        job.seq      = SEQ_READ;
                        job.addr     = bus_addr(ID_DEVICE_ADDR);
                    end
                    PH_ID_LOW:
                    begin
                        job.seq       = SEQ_ID_DONE;
                        job.host_data = {id_high_reg, req.read_data};
                    end
                    default:
                        // response while idle is dropped
                        job_valid = 1'b0;
                endcase
            end
            else if (phase_reg != PH_IDLE)
            begin
                job.seq = SEQ_REJECT;
            end
            else
            begin
                unique case (op)
                    OP_READ:
                    begin
                        job.seq  = SEQ_READ;
                        job.addr = bus_addr(req.address);
                    end
                    OP_WRITE:
                    begin
                        job.seq  = SEQ_WRITE;
                        job.addr = bus_addr(req.address);
                        job.data = req.data;
                    end
                    OP_PROGRAM:
                    begin
                        job.seq        = SEQ_PROGRAM;
                        job.addr       = bus_addr(req.address);
                        job.data       = req.data;
                        poll_addr_next = bus_addr(req.address);
                        expected_next  = req.data;
                    end
                    OP_SECTOR_ERASE:
                    begin
                        job.seq        = SEQ_SECTOR_ERASE;
                        job.addr       = sector_addr;
                        poll_addr_next = sector_addr;
                        expected_next  = ERASED_BYTE;
                    end
                    OP_CHIP_ERASE:
                    begin
                        job.seq        = SEQ_CHIP_ERASE;
                        job.addr       = bus_addr(ID_FAMILY_ADDR);
                        poll_addr_next = bus_addr(ID_FAMILY_ADDR);
                        expected_next  = ERASED_BYTE;
                    end
                    OP_READ_ID:
                    begin
                        job.seq  = SEQ_READ_ID;
                        job.addr = bus_addr(ID_FAMILY_ADDR);
                    end
                    default:
                        job.seq = SEQ_UNPROTECT;
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            poll_addr_reg <= '0;
            expected_reg  <= '0;
            id_high_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            poll_addr_reg <= poll_addr_next;
            expected_reg  <= expected_next;
            id_high_reg   <= id_high_next;
        end
    end

endmodule

### design/pfcs_queue.sv
// Short job queue between the front and back ends of the command sequencer.
// Depends on pfcs_pkg.

module pfcs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  pfcs_pkg::job_t  push_job,
    output logic            pop_valid,
    input  logic            pop_ready,
    output pfcs_pkg::job_t  pop_job
);
    import pfcs_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### design/pfcs_back.sv
// Back end: plays each job's bus cycle list, one result per cycle unless held off.
// Depends on pfcs_pkg and pfcs_res_if.

module pfcs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  pfcs_pkg::job_t  job,
    pfcs_res_if.source      res
);
    import pfcs_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg;
    res_t              cur;
    logic              load;

    // One write of the three-write unlock sequence; the third carries the command
    function automatic res_t unlock_cycle(logic [STEP_W-1:0] idx, logic [7:0] cmd);
        res_t r;
        r      = '0;
        r.kind = KIND_WRITE;
        case (idx)
            STEP_W'(0):
            begin
                r.bus_address = bus_addr(UNLOCK_ADDR1);
                r.bus_data    = UNLOCK_DATA1;
            end
            STEP_W'(1):
            begin
                r.bus_address = bus_addr(UNLOCK_ADDR2);
                r.bus_data    = UNLOCK_DATA2;
            end
            default:
            begin
                r.bus_address = bus_addr(UNLOCK_ADDR1);
                r.bus_data    = cmd;
            end
        endcase
        return r;
    endfunction

    // Result for step s of job j
    function automatic res_t step_res(job_t j, logic [STEP_W-1:0] s);
        res_t r;
        logic first_group;
        logic [STEP_W-1:0] s2;
        r           = '0;
        first_group = (s < STEP_W'(3));
        s2          = s - STEP_W'(3);
        unique case (j.seq)
            SEQ_READ:
            begin
                r.kind        = KIND_READ;
                r.bus_address = j.addr;
                r.last        = 1'b1;
            end
            SEQ_WRITE:
            begin
                r.kind        = KIND_WRITE;
                r.bus_address = j.addr;
                r.bus_data    = j.data;
                r.done_res    = 1'b1;
                r.last        = 1'b1;
            end
            SEQ_DONE:
            begin
                r.kind      = KIND_DONE;
                r.host_data = j.host_data;
                r.done_res  = 1'b1;
                r.last      = 1'b1;
            end
            SEQ_REJECT:
            begin
                r.kind = KIND_REJECT;
                r.last = 1'b1;
            end
            SEQ_PROGRAM:
            begin
                if (first_group)
                    r = unlock_cycle(s, CMD_PROGRAM);
                else if (s == STEP_W'(3))
                begin
                    r.kind        = KIND_WRITE;
                    r.bus_address = j.addr;
                    r.bus_data    = j.data;
                end
                else
                begin
                    r.kind        = KIND_READ;
                    r.bus_address = j.addr;
                    r.last        = 1'b1;
                end
            end
            SEQ_SECTOR_ERASE:
            begin
                if (first_group)
                    r = unlock_cycle(s, CMD_ERASE_SETUP);
                else if (s < STEP_W'(5))
                    r = unlock_cycle(s2, CMD_SECTOR_ERASE);
                else if (s == STEP_W'(5))
                begin
                    r.kind        = KIND_WRITE;
                    r.bus_address = j.addr;
                    r.bus_data    = CMD_SECTOR_ERASE;
                end
                else
                begin
                    r.kind        = KIND_READ;
                    r.bus_address = j.addr;
                    r.last        = 1'b1;
                end
            end
            SEQ_CHIP_ERASE:
            begin
                if (first_group)
                    r = unlock_cycle(s, CMD_ERASE_SETUP);
                else if (s < STEP_W'(6))
                    r = unlock_cycle(s2, CMD_CHIP_ERASE);
                else
                begin
                    r.kind        = KIND_READ;
                    r.bus_address = j.addr;
                    r.last        = 1'b1;
                end
            end
            SEQ_UNPROTECT:
            begin
                if (first_group)
                    r = unlock_cycle(s, CMD_ERASE_SETUP);
                else
                begin
                    r = unlock_cycle(s2, CMD_UNPROTECT);
                    if (s >= STEP_W'(5))
                    begin
                        r.done_res = 1'b1;
                        r.last     = 1'b1;
                    end
                end
            end
            SEQ_READ_ID:
            begin
                if (first_group)
                    r = unlock_cycle(s, CMD_ID_ENTRY);
                else
                begin
                    r.kind        = KIND_READ;
                    r.bus_address = j.addr;
                    r.last        = 1'b1;
                end
            end
            SEQ_ID_DONE:
            begin
                if (first_group)
                    r = unlock_cycle(s, CMD_ID_EXIT);
                else
                begin
                    r.kind      = KIND_DONE;
                    r.host_data = j.host_data;
                    r.done_res  = 1'b1;
                    r.last      = 1'b1;
                end
            end
            default:
            begin
                r.kind = KIND_REJECT;
                r.last = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Load a job's next result when the output register is free or being drained
    assign cur       = step_res(job, step_reg);
    assign load      = job_valid && (!out_valid_reg || res.ready);
    assign job_ready = load && cur.last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = cur.last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= cur;
    end

    assign res.valid       = out_valid_reg;
    assign res.cycle_kind  = out_data_reg.kind;
    assign res.bus_address = out_data_reg.bus_address;
    assign res.bus_data    = out_data_reg.bus_data;
    assign res.host_data   = out_data_reg.host_data;
    assign res.done_res    = out_data_reg.done_res;
    assign res.last        = out_data_reg.last;

endmodule

### design/parallel_flash_command_sequencer.sv
// An accepted request is written into the job queue, then its first result is loaded into
// the output register. Throughput: one result per cycle while the result side is ready;
// a request gives one result per bus cycle: 0 for a dropped response, 1 to 7 otherwise,
// and 7 for an erase with its poll read.
// Requests are accepted every cycle while the two-entry job queue has room; a held result
// stalls the back end, then the queue, then the request side.
// Reset (rst_n low, asynchronous): phase idle, poll/id registers zero, queue and output empty.
// Top level of the parallel flash command sequencer; depends on pfcs_pkg, both interfaces,
// pfcs_front, pfcs_queue and pfcs_back.

module parallel_flash_command_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    pfcs_req_if.sink   req,
    pfcs_res_if.source res
);
    import pfcs_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    pfcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    pfcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    pfcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .res       (res)
    );

`ifndef SYNTHESIS
    // A rejected request carries nothing but the last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.cycle_kind == KIND_REJECT) |->
            (res.last && !res.done_res && res.bus_address == 16'h0000
             && res.host_data == 16'h0000))
        else $error("reject result carries payload");

    // A completion always finishes the operation and ends the request's results
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.cycle_kind == KIND_DONE) |-> (res.done_res && res.last))
        else $error("completion without done/last");

    // A host request into an empty pipeline reaches the result via queue and output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.operation != OP_BUS_RESP && !pop_valid
         && !res.valid) |=> ##1 res.valid)
        else $error("request result missing");
`endif

endmodule

### bench/tb_parallel_flash_command_sequencer.sv
`timescale 1ns / 100ps
// Self-checking testbench for parallel_flash_command_sequencer: predicts bus cycles per request.
// Depends on pfcs_pkg, pfcs_req_if, pfcs_res_if and the sequencer RTL.

module tb_parallel_flash_command_sequencer;
    import pfcs_pkg::*;

    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 200;
    localparam int TARGET_REQUESTS = 330;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  sector;
        logic [7:0]  read_data;
    } host_req_t;

    logic clk = 1'b0;
    logic rst_n;

    pfcs_req_if req_ch();
    pfcs_res_if res_ch();

    parallel_flash_command_sequencer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    // Predicted sequencer state
    phase_t      model_phase     = PH_IDLE;
    logic [15:0] model_poll_addr = '0;
    logic [7:0]  model_poll_byte = '0;
    logic [7:0]  model_id_family = '0;

    // Bus cycles still owed by the block, oldest first
    res_t bus_cycle_q[$];

    int fault_count   = 0;
    int live_requests = 0;
    int src_gap_max   = 0;
    int stall_max     = 0;
    int sink_stall    = 0;
    int sink_hold     = 0;

    // ---------------------------------------------------------------
    // Bus cycle predictor
    // ---------------------------------------------------------------
    function automatic void add_cycle(kind_t k, logic [15:0] a, logic [7:0] bd,
                                      logic [15:0] hd, logic d);
        res_t c;
        c.kind        = k;
        c.bus_address = a & BUS_ADDR_MASK;
        c.bus_data    = bd;
        c.host_data   = hd;
        c.done_res    = d;
        c.last        = 1'b0;
        bus_cycle_q.push_back(c);
    endfunction

    // JEDEC unlock pair followed by a command write
    function automatic void add_unlock(logic [7:0] cmd);
        add_cycle(KIND_WRITE, UNLOCK_ADDR1, UNLOCK_DATA1, '0, 1'b0);
        add_cycle(KIND_WRITE, UNLOCK_ADDR2, UNLOCK_DATA2, '0, 1'b0);
        add_cycle(KIND_WRITE, UNLOCK_ADDR1, cmd, '0, 1'b0);
    endfunction

    function automatic void begin_poll(logic [15:0] a, logic [7:0] want);
        model_poll_addr = a & BUS_ADDR_MASK;
        model_poll_byte = want;
        model_phase     = PH_POLL;
        add_cycle(KIND_READ, model_poll_addr, '0, '0, 1'b0);
    endfunction

    function automatic void predict_bus_cycles(host_req_t it);
        int base;
        base = bus_cycle_q.size();
        if (it.op == OP_BUS_RESP) begin
            case (model_phase)
                PH_READ: begin
                    add_cycle(KIND_DONE, '0, '0, {8'h00, it.read_data}, 1'b1);
                    model_phase = PH_IDLE;
                end
                PH_POLL: begin
                    if (it.read_data == model_poll_byte) begin
                        add_cycle(KIND_DONE, '0, '0, {8'h00, it.read_data}, 1'b1);
                        model_phase = PH_IDLE;
                    end else begin
                        add_cycle(KIND_READ, model_poll_addr, '0, '0, 1'b0);
                    end
                end
                PH_ID_HIGH: begin
                    model_id_family = it.read_data;
                    add_cycle(KIND_READ, ID_DEVICE_ADDR, '0, '0, 1'b0);
                    model_phase = PH_ID_LOW;
                end
                PH_ID_LOW: begin
                    add_unlock(CMD_ID_EXIT);
                    add_cycle(KIND_DONE, '0, '0, {model_id_family, it.read_data}, 1'b1);
                    model_phase = PH_IDLE;
                end
                default: ;  // stray bus response is dropped
            endcase
        end else if (model_phase != PH_IDLE) begin
            add_cycle(KIND_REJECT, '0, '0, '0, 1'b0);
        end else begin
            case (it.op)
                OP_READ: begin
                    add_cycle(KIND_READ, it.address, '0, '0, 1'b0);
                    model_phase = PH_READ;
                end
                OP_WRITE:
                    add_cycle(KIND_WRITE, it.address, it.data, '0, 1'b1);
                OP_PROGRAM: begin
                    add_unlock(CMD_PROGRAM);
                    add_cycle(KIND_WRITE, it.address, it.data, '0, 1'b0);
                    begin_poll(it.address, it.data);
                end
                OP_SECTOR_ERASE: begin
                    add_unlock(CMD_ERASE_SETUP);
                    add_cycle(KIND_WRITE, UNLOCK_ADDR1, UNLOCK_DATA1, '0, 1'b0);
                    add_cycle(KIND_WRITE, UNLOCK_ADDR2, UNLOCK_DATA2, '0, 1'b0);
                    add_cycle(KIND_WRITE, {it.sector, 8'h00}, CMD_SECTOR_ERASE, '0, 1'b0);
                    begin_poll({it.sector, 8'h00}, ERASED_BYTE);
                end
                OP_CHIP_ERASE: begin
                    add_unlock(CMD_ERASE_SETUP);
                    add_unlock(CMD_CHIP_ERASE);
                    begin_poll('0, ERASED_BYTE);
                end
                OP_READ_ID: begin
                    add_unlock(CMD_ID_ENTRY);
                    add_cycle(KIND_READ, ID_FAMILY_ADDR, '0, '0, 1'b0);
                    model_phase = PH_ID_HIGH;
                end
                default: begin
                    add_unlock(CMD_ERASE_SETUP);
                    add_unlock(CMD_UNPROTECT);
                    bus_cycle_q[bus_cycle_q.size() - 1].done_res = 1'b1;
                end
            endcase
        end
        if (bus_cycle_q.size() > base)
            bus_cycle_q[bus_cycle_q.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Request helpers
    // ---------------------------------------------------------------
    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic host_req_t make_item(op_t op, logic [15:0] a, logic [7:0] d,
                                            logic [7:0] s, logic [7:0] rd);
        host_req_t it;
        it.op        = op;
        it.address   = a;
        it.data      = d;
        it.sector    = s;
        it.read_data = rd;
        return it;
    endfunction

    function automatic host_req_t random_item(op_t op);
        return make_item(op, pick_addr(), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    // Drive one request at the falling edge, hold it until accepted
    task automatic send_request(input host_req_t it);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.operation = it.op;
        req_ch.address   = it.address;
        req_ch.data      = it.data;
        req_ch.sector    = it.sector;
        req_ch.read_data = it.read_data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (!(it.op == OP_BUS_RESP && model_phase == PH_IDLE))
            live_requests++;
        predict_bus_cycles(it);
        @(negedge clk);
    endtask

    // Bus response carrying the byte read from memory
    task automatic respond(input logic [7:0] rd);
        host_req_t it;
        it = random_item(OP_BUS_RESP);
        it.read_data = rd;
        send_request(it);
    endtask

    // Stop offering and let every owed bus cycle come out
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (bus_cycle_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One host operation followed by the responses it needs, with occasional
    // interfering requests that must be rejected
    task automatic run_operation(input op_t op);
        host_req_t it;
        int        polls;
        polls = 0;
        send_request(random_item(op));
        while (model_phase != PH_IDLE) begin
            it = random_item(OP_BUS_RESP);
            if ($urandom_range(0, 9) == 0) begin
                it.op = op_t'($urandom_range(0, 6));
            end else if (model_phase == PH_POLL) begin
                if (polls >= 6 || $urandom_range(0, 99) < 40)
                    it.read_data = model_poll_byte;
                polls++;
            end
            send_request(it);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_plain_access();
        send_request(make_item(OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00));
        respond(8'h00);
        send_request(make_item(OP_READ, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        respond(8'hFF);
        send_request(make_item(OP_WRITE, 16'h0000, 8'hFF, 8'h00, 8'h00));
        send_request(make_item(OP_WRITE, 16'hFFFF, 8'h00, 8'hFF, 8'hFF));
    endtask

    task automatic test_flash_program();
        // one failed poll before the programmed byte shows up
        send_request(make_item(OP_PROGRAM, 16'hFFFF, 8'h00, 8'h00, 8'h00));
        respond(8'hAA);
        respond(8'h00);
        send_request(make_item(OP_PROGRAM, 16'h0000, 8'hFF, 8'hFF, 8'hFF));
        respond(8'hFF);
    endtask

    task automatic test_erase();
        send_request(make_item(OP_SECTOR_ERASE, 16'h0000, 8'h00, 8'hFF, 8'h00));
        respond(8'h00);
        respond(8'hFF);
        send_request(make_item(OP_CHIP_ERASE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        respond(8'hFF);
        send_request(make_item(OP_SECTOR_ERASE, 16'hFFFF, 8'hFF, 8'h00, 8'hFF));
        respond(8'hFF);
    endtask

    task automatic test_id_and_unprotect();
        send_request(make_item(OP_READ_ID, 16'h0000, 8'h00, 8'h00, 8'h00));
        respond(8'hFF);
        respond(8'h00);
        send_request(make_item(OP_UNPROTECT, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_busy_and_stray();
        // bus response with nothing outstanding is dropped
        respond(8'h3C);
        send_request(make_item(OP_READ, 16'h1234, 8'h00, 8'h00, 8'h00));
        // new request while the read waits for its byte
        send_request(make_item(OP_WRITE, 16'h4321, 8'hA5, 8'h00, 8'h00));
        respond(8'h5A);
    endtask

    // Result side holds off while requests keep coming, so the job queue fills
    task automatic test_input_backpressure();
        wait_drained();
        src_gap_max = 0;
        sink_hold   = HOLD_CYCLES;
        repeat (12) begin
            if ($urandom_range(0, 1) == 0)
                send_request(random_item(OP_WRITE));
            else
                send_request(random_item(OP_UNPROTECT));
        end
        // sender pauses until everything is out before the next operation
        wait_drained();
        run_operation(OP_PROGRAM);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int pick;
        int seq_count;
        seq_count = 0;
        while (live_requests < TARGET_REQUESTS) begin
            // new pacing for each stretch, sometimes with no idling at all
            if (seq_count % 16 == 0) begin
                src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
                stall_max   = ($urandom_range(0, 2) == 0) ? 0 : 14;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)
                run_operation(op_t'($urandom_range(0, 6)));
            else
                send_request(random_item(op_t'($urandom_range(0, 7))));
            if (pick >= 97)
                wait_drained();
            seq_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: ready pacing and checking
    // ---------------------------------------------------------------
    initial begin : result_sink
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold > 0) begin
                res_ch.ready = 1'b0;
                sink_hold--;
            end else if (sink_stall > 0) begin
                res_ch.ready = 1'b0;
                sink_stall--;
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        res_t got;
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.kind        = kind_t'(res_ch.cycle_kind);
            got.bus_address = res_ch.bus_address;
            got.bus_data    = res_ch.bus_data;
            got.host_data   = res_ch.host_data;
            got.done_res    = res_ch.done_res;
            got.last        = res_ch.last;
            sink_stall = $urandom_range(0, stall_max);
            if (bus_cycle_q.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected bus cycle: kind=%0d addr=%h bd=%h hd=%h done=%b last=%b",
                             got.kind, got.bus_address, got.bus_data, got.host_data,
                             got.done_res, got.last);
            end else begin
                want = bus_cycle_q.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("bus cycle differs at %0t", $realtime);
                        $display("  expected kind=%0d addr=%h bd=%h hd=%h done=%b last=%b",
                                 want.kind, want.bus_address, want.bus_data,
                                 want.host_data, want.done_res, want.last);
                        $display("  actual   kind=%0d addr=%h bd=%h hd=%h done=%b last=%b",
                                 got.kind, got.bus_address, got.bus_data,
                                 got.host_data, got.done_res, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no handshake happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("parallel_flash_command_sequencer: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin : test_sequence
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_READ;
        req_ch.address   = '0;
        req_ch.data      = '0;
        req_ch.sector    = '0;
        req_ch.read_data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_plain_access();
        test_flash_program();
        test_erase();
        test_id_and_unprotect();
        test_busy_and_stray();
        test_input_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bus_cycle_q.size() != 0) begin
            $display("%0d bus cycles never arrived", bus_cycle_q.size());
            fault_count += bus_cycle_q.size();
        end
        if (fault_count == 0)
            $display("parallel_flash_command_sequencer: match");
        else
            $display("parallel_flash_command_sequencer: mismatch");
        $finish;
    end

endmodule
